@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the memory decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Condition that must never be true at a clock edge
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");

`endif

@@ hdl/mmm_pkg.sv @@
// Types and constants of the memory decoder with I/O registers
`timescale 1ns / 1ps
`default_nettype none

package mmm_pkg;

  localparam int unsigned RAM_BYTES = 32768;
  localparam int unsigned ROM_BYTES = 16384;
  localparam int unsigned MEM_AW    = 16;   // RAM, paged ROM and OS ROM share one array
  localparam int unsigned ROM_AW    = $clog2(ROM_BYTES);

  // High address bits of each ROM image inside the shared array
  localparam logic [1:0] PAGED_ROM_BASE = 2'b10;
  localparam logic [1:0] OS_ROM_BASE    = 2'b11;
  localparam logic [7:0] IO_PAGE_HI     = 8'hFE;

  typedef enum logic [1:0] {
    MODE_READ       = 2'd0,
    MODE_WRITE      = 2'd1,
    MODE_LOAD_OS    = 2'd2,
    MODE_LOAD_PAGED = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ROM_WRITE = 2'd1,
    ST_BAD_IO    = 2'd2
  } status_e;

  // I/O register offsets (address bits 3..0 after the FF0F mask)
  localparam logic [3:0] IO_IRQ    = 4'h0;
  localparam logic [3:0] IO_SCR_LO = 4'h2;
  localparam logic [3:0] IO_SCR_HI = 4'h3;
  localparam logic [3:0] IO_CASS   = 4'h4;
  localparam logic [3:0] IO_PAGE   = 4'h5;
  localparam logic [3:0] IO_COUNT  = 4'h6;
  localparam logic [3:0] IO_MISC   = 4'h7;

  localparam logic [7:0] IRQ_STATUS_RST = 8'h82;
  localparam logic [7:0] IRQ_POWER_ON   = 8'h02;

  typedef struct packed {
    logic       rd;
    logic       wr;
    logic [3:0] idx;
    logic [7:0] wdata;
  } io_req_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       bad;
    logic [3:0] page_next;
  } io_rsp_t;

  typedef struct packed {
    logic [3:0] page;
    status_e    status;
    logic [7:0] data;
  } out_word_t;

endpackage

`default_nettype wire

@@ hdl/mmm_mem.sv @@
// Shared byte array for RAM, paged ROM and OS ROM, registered synchronous read
`timescale 1ns / 1ps
`default_nettype none

module mmm_mem (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic                       re_i,
  input  wire logic [mmm_pkg::MEM_AW-1:0] addr_i,
  input  wire logic [7:0]                 wdata_i,
  output logic      [7:0]                 rdata_o
);

  logic [7:0] mem_q [2**mmm_pkg::MEM_AW];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/mmm_io.sv @@
// Interrupt, screen, paging, control and palette registers of the I/O page
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mmm_io (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mmm_pkg::io_req_t req_i,
  output mmm_pkg::io_rsp_t      rsp_o
);

  logic [7:0] irq_status_q, irq_status_d;
  logic [7:0] irq_enable_q, irq_enable_d;
  logic [7:0] scr_lo_q, scr_lo_d;
  logic [7:0] scr_hi_q, scr_hi_d;
  logic [3:0] rom_page_q, rom_page_d;
  logic [7:0] misc_q, misc_d;
  logic [7:0] pal_q [8];
  logic [7:0] pal_d [8];

  always_comb begin
    irq_status_d = irq_status_q;
    irq_enable_d = irq_enable_q;
    scr_lo_d     = scr_lo_q;
    scr_hi_d     = scr_hi_q;
    rom_page_d   = rom_page_q;
    misc_d       = misc_q;
    pal_d        = pal_q;
    rsp_o.rdata  = '0;
    rsp_o.bad    = 1'b0;

    if (req_i.rd) begin
      if (req_i.idx[3]) begin
        rsp_o.rdata = pal_q[req_i.idx[2:0]];
      end else begin
        case (req_i.idx)
          mmm_pkg::IO_IRQ: begin
            rsp_o.rdata  = irq_status_q;
            irq_status_d = irq_status_q & ~mmm_pkg::IRQ_POWER_ON;
          end
          mmm_pkg::IO_CASS: begin
          end
          mmm_pkg::IO_MISC: begin
            rsp_o.rdata = misc_q;
          end
          default: begin
            rsp_o.bad = 1'b1;
          end
        endcase
      end
    end

    if (req_i.wr) begin
      if (req_i.idx[3]) begin
        pal_d[req_i.idx[2:0]] = req_i.wdata;
      end else begin
        case (req_i.idx)
          mmm_pkg::IO_IRQ:    irq_enable_d = req_i.wdata;
          mmm_pkg::IO_SCR_LO: scr_lo_d = req_i.wdata;
          mmm_pkg::IO_SCR_HI: scr_hi_d = req_i.wdata;
          mmm_pkg::IO_CASS: begin
          end
          mmm_pkg::IO_PAGE: begin
            rom_page_d = req_i.wdata[3:0];
            // acknowledge bits drop the matching enables; NMI bit is ignored
            if (req_i.wdata[6]) irq_enable_d[6] = 1'b0;
            if (req_i.wdata[5]) irq_enable_d[3] = 1'b0;
            if (req_i.wdata[4]) irq_enable_d[2] = 1'b0;
          end
          mmm_pkg::IO_COUNT: begin
          end
          mmm_pkg::IO_MISC: misc_d = req_i.wdata;
          default: begin
            rsp_o.bad = 1'b1;
          end
        endcase
      end
    end

    rsp_o.page_next = rom_page_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_status_q <= mmm_pkg::IRQ_STATUS_RST;
      irq_enable_q <= '0;
      scr_lo_q     <= '0;
      scr_hi_q     <= '0;
      rom_page_q   <= '0;
      misc_q       <= '0;
      for (int i = 0; i < 8; i++) begin
        pal_q[i] <= '0;
      end
    end else begin
      irq_status_q <= irq_status_d;
      irq_enable_q <= irq_enable_d;
      scr_lo_q     <= scr_lo_d;
      scr_hi_q     <= scr_hi_d;
      rom_page_q   <= rom_page_d;
      misc_q       <= misc_d;
      pal_q        <= pal_d;
    end
  end

  `ASSERT_CLK(a_status_read_clears, (req_i.rd && req_i.idx == mmm_pkg::IO_IRQ) |=> !irq_status_q[1])
  `ASSERT_CLK(a_page_ack_clears, (req_i.wr && req_i.idx == mmm_pkg::IO_PAGE && req_i.wdata[6]) |=> !irq_enable_q[6])
  `ASSERT_CLK(a_screen_hold, (!req_i.wr) |=> ($stable(scr_lo_q) && $stable(scr_hi_q)))

endmodule

`default_nettype wire

@@ hdl/micro_memory_map_with_io_registers.sv @@
// Top level: bus decoder with shared memory array, I/O registers and output stage
//
// Input channel (s_axis_*): one CPU access or ROM load per word. tuser carries the
// mode (bus read, bus write, OS ROM load, paged ROM load); tdata carries the
// address and the write byte. Output channel (m_axis_*): one result word per
// input word, in order, with the read byte, a status code and the ROM page.
// The decode stage issues the memory access and the I/O register update as a
// word is accepted and registers its result fields, while the shared array
// registers its synchronous read; the output register then takes the read byte
// or the I/O result from them.
// Throughput: one word per cycle while the receiver takes words.
// When the receiver stalls, the output register and the decode stage hold, and
// s_axis_tready drops once both are full; no word is dropped.
// Reset: I/O registers return to their power-on values (interrupt status 0x82,
// all else zero) and both stages empty. RAM and ROM contents are not cleared and
// must be written or loaded before they are read.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module micro_memory_map_with_io_registers (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] address, [23:16] write_data
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata    // [7:0] read_data, [9:8] status,
                                           // [13:10] rom_page_select
);

  mmm_pkg::mode_e             mode;
  logic [15:0]                addr;
  logic [7:0]                 wdata;
  logic                       accept;
  logic                       is_ram, is_io;
  logic                       mem_we, mem_re;
  logic [mmm_pkg::MEM_AW-1:0] mem_addr;
  logic [7:0]                 mem_rdata;
  mmm_pkg::io_req_t           io_req;
  mmm_pkg::io_rsp_t           io_rsp;
  mmm_pkg::status_e           status;

  logic                       s1_valid_q, s1_valid_d;
  logic                       s1_mem_q;
  logic [7:0]                 s1_data_q;
  mmm_pkg::status_e           s1_status_q;
  logic [3:0]                 s1_page_q;
  logic                       s1_adv;

  logic                       out_valid_q, out_valid_d;
  mmm_pkg::out_word_t         out_q;

  assign mode   = mmm_pkg::mode_e'(s_axis_tuser);
  assign addr   = s_axis_tdata[15:0];
  assign wdata  = s_axis_tdata[23:16];
  assign accept = s_axis_tvalid && s_axis_tready;
  assign is_ram = !addr[15];
  assign is_io  = addr[15:8] == mmm_pkg::IO_PAGE_HI;

  // decode: memory access or I/O register access
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = addr;
    io_req.rd    = 1'b0;
    io_req.wr    = 1'b0;
    io_req.idx   = addr[3:0];
    io_req.wdata = wdata;
    case (mode)
      mmm_pkg::MODE_READ: begin
        mem_re    = accept && !is_io;
        io_req.rd = accept && is_io;
      end
      mmm_pkg::MODE_WRITE: begin
        mem_we    = accept && is_ram;
        io_req.wr = accept && is_io;
      end
      mmm_pkg::MODE_LOAD_OS: begin
        mem_we   = accept;
        mem_addr = {mmm_pkg::OS_ROM_BASE, addr[mmm_pkg::ROM_AW-1:0]};
      end
      mmm_pkg::MODE_LOAD_PAGED: begin
        mem_we   = accept;
        mem_addr = {mmm_pkg::PAGED_ROM_BASE, addr[mmm_pkg::ROM_AW-1:0]};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status = mmm_pkg::ST_OK;
    if ((mode == mmm_pkg::MODE_READ || mode == mmm_pkg::MODE_WRITE) && is_io) begin
      status = io_rsp.bad ? mmm_pkg::ST_BAD_IO : mmm_pkg::ST_OK;
    end else if (mode == mmm_pkg::MODE_WRITE && !is_ram) begin
      status = mmm_pkg::ST_ROM_WRITE;
    end
  end

  mmm_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (wdata),
    .rdata_o (mem_rdata)
  );

  mmm_io u_io (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (io_req),
    .rsp_o  (io_rsp)
  );

  // advance the decode stage only when the output register frees up
  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s1_valid_d    = accept || (s1_valid_q && !s1_adv);
  assign out_valid_d   = s1_adv || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mem_q    <= mem_re;
      s1_data_q   <= io_rsp.rdata;
      s1_status_q <= status;
      s1_page_q   <= io_rsp.page_next;
    end
    if (s1_adv) begin
      out_q.data   <= s1_mem_q ? mem_rdata : s1_data_q;
      out_q.status <= s1_status_q;
      out_q.page   <= s1_page_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

  `ASSERT_NEVER(a_mem_one_port, mem_we && mem_re)
  `ASSERT_CLK(a_full_blocks_input, (s1_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
  `ASSERT_CLK(a_rom_write_no_data, (out_valid_q && out_q.status == mmm_pkg::ST_ROM_WRITE) |-> out_q.data == 8'h00)

endmodule

`default_nettype wire

@@ dv/micro_memory_map_with_io_registers_tb.sv @@
// Self-checking testbench for the memory decoder with I/O registers
`timescale 1ns / 1ps

module micro_memory_map_with_io_registers_tb;

  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_style_e;

  // Tracks the decoder state and the results it owes, in order of acceptance
  class decoder_scoreboard;
    logic [7:0] ram_img   [mmm_pkg::RAM_BYTES];
    logic [7:0] paged_img [mmm_pkg::ROM_BYTES];
    logic [7:0] os_img    [mmm_pkg::ROM_BYTES];
    logic [7:0] palette   [8];
    logic [7:0] irq_status, irq_enable, scr_lo, scr_hi, misc_ctrl;
    logic [3:0] page;
    mmm_pkg::out_word_t owed_q [$];
    int unsigned errors;

    function new();
      irq_status = mmm_pkg::IRQ_STATUS_RST;
      irq_enable = '0;
      scr_lo     = '0;
      scr_hi     = '0;
      misc_ctrl  = '0;
      page       = '0;
      foreach (palette[i]) palette[i] = '0;
      errors = 0;
    endfunction

    function void note_access(mmm_pkg::mode_e m, logic [15:0] a, logic [7:0] d);
      mmm_pkg::out_word_t w;
      logic [3:0]         idx;
      w.data   = '0;
      w.status = mmm_pkg::ST_OK;
      idx      = a[3:0];   // FF0F mask leaves only the low nibble inside the I/O page
      case (m)
        mmm_pkg::MODE_READ: begin
          if (!a[15]) w.data = ram_img[a[14:0]];
          else if (a[15:14] == mmm_pkg::PAGED_ROM_BASE) w.data = paged_img[a[13:0]];
          else if (a[15:8] == mmm_pkg::IO_PAGE_HI) begin
            if (idx[3]) w.data = palette[idx[2:0]];
            else begin
              case (idx)
                mmm_pkg::IO_IRQ: begin
                  w.data = irq_status;
                  irq_status = irq_status & ~mmm_pkg::IRQ_POWER_ON;
                end
                mmm_pkg::IO_CASS: ;
                mmm_pkg::IO_MISC: w.data = misc_ctrl;
                default: w.status = mmm_pkg::ST_BAD_IO;
              endcase
            end
          end else w.data = os_img[a[13:0]];
        end
        mmm_pkg::MODE_WRITE: begin
          if (!a[15]) ram_img[a[14:0]] = d;
          else if (a[15:8] == mmm_pkg::IO_PAGE_HI) begin
            if (idx[3]) palette[idx[2:0]] = d;
            else begin
              case (idx)
                mmm_pkg::IO_IRQ:    irq_enable = d;
                mmm_pkg::IO_SCR_LO: scr_lo = d;
                mmm_pkg::IO_SCR_HI: scr_hi = d;
                mmm_pkg::IO_CASS, mmm_pkg::IO_COUNT: ;
                mmm_pkg::IO_PAGE: begin
                  page = d[3:0];
                  if (d[6]) irq_enable = irq_enable & ~8'h40;
                  if (d[5]) irq_enable = irq_enable & ~8'h08;
                  if (d[4]) irq_enable = irq_enable & ~8'h04;
                end
                mmm_pkg::IO_MISC:   misc_ctrl = d;
                default:            w.status = mmm_pkg::ST_BAD_IO;
              endcase
            end
          end else w.status = mmm_pkg::ST_ROM_WRITE;
        end
        mmm_pkg::MODE_LOAD_OS: os_img[a[13:0]] = d;
        default:               paged_img[a[13:0]] = d;
      endcase
      w.page = page;
      owed_q.push_back(w);
    endfunction

    function void check_result(logic [15:0] word);
      mmm_pkg::out_word_t got, want;
      got = mmm_pkg::out_word_t'(word[13:0]);
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result word %h, none expected", $time, word);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (word[15:14] !== 2'b00) begin
        $display("%0t: pad bits expected 0 actual %b", $time, word[15:14]);
        errors++;
      end
      if (got.data !== want.data) begin
        $display("%0t: read_data expected %h actual %h", $time, want.data, got.data);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.page !== want.page) begin
        $display("%0t: rom_page_select expected %h actual %h", $time, want.page, got.page);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = mmm_pkg::MODE_READ;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  decoder_scoreboard sb;
  int unsigned       burst_left    = 0;
  bit                long_hold_req = 1'b0;
  int unsigned       cycles        = 0;
  logic [15:0]       ram_addrs  [$];
  logic [13:0]       os_offs    [$];
  logic [13:0]       paged_offs [$];

  micro_memory_map_with_io_registers dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Offer one word in bursts with random gaps; remember what has been stored
  task automatic send_access(input mmm_pkg::mode_e m, input logic [15:0] a,
                             input logic [7:0] d);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    if (m == mmm_pkg::MODE_WRITE && !a[15]) ram_addrs.push_back(a);
    if (m == mmm_pkg::MODE_LOAD_OS) os_offs.push_back(a[13:0]);
    if (m == mmm_pkg::MODE_LOAD_PAGED) paged_offs.push_back(a[13:0]);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= m;
    s_axis_tdata  <= {8'h00, d, a};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_access(m, a, d);
    burst_left--;
  endtask

  initial begin : rx_pacing
    rx_style_e   style;
    int unsigned span, period, tick;
    @(posedge rst_ni);
    forever begin
      style  = rx_style_e'($urandom_range(0, 3));
      span   = $urandom_range(50, 400);
      period = $urandom_range(2, 5);
      for (tick = 0; tick < span; tick++) begin
        @(posedge clk_i);
        if (long_hold_req) begin
          // hold off long enough that both stages fill and the input stalls
          long_hold_req = 1'b0;
          m_axis_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk_i);
        end
        case (style)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready <= (tick % period == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned n, pick;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_access(mmm_pkg::MODE_READ,  16'hFE00, 8'h00);   // power-on bit set
    send_access(mmm_pkg::MODE_READ,  16'hFE00, 8'h00);   // and now cleared
    send_access(mmm_pkg::MODE_WRITE, 16'hFE00, 8'hFF);
    send_access(mmm_pkg::MODE_WRITE, 16'hFE05, 8'hFF);
    send_access(mmm_pkg::MODE_WRITE, 16'hFE05, 8'h8A);   // NMI bit has no effect
    send_access(mmm_pkg::MODE_WRITE, 16'hFE02, 8'h12);
    send_access(mmm_pkg::MODE_WRITE, 16'hFE03, 8'h34);
    send_access(mmm_pkg::MODE_WRITE, 16'hFE04, 8'h55);
    send_access(mmm_pkg::MODE_WRITE, 16'hFE06, 8'hAA);
    send_access(mmm_pkg::MODE_READ,  16'hFE04, 8'h00);
    send_access(mmm_pkg::MODE_WRITE, 16'hFE07, 8'hA5);
    send_access(mmm_pkg::MODE_READ,  16'hFEF7, 8'h00);   // mirror of misc control
    send_access(mmm_pkg::MODE_WRITE, 16'hFE3F, 8'hFF);
    send_access(mmm_pkg::MODE_READ,  16'hFE0F, 8'h00);
    send_access(mmm_pkg::MODE_READ,  16'hFE01, 8'h00);   // unknown register
    send_access(mmm_pkg::MODE_WRITE, 16'hFEF1, 8'h77);
    send_access(mmm_pkg::MODE_READ,  16'hFE05, 8'h00);
    send_access(mmm_pkg::MODE_WRITE, 16'h8000, 8'h11);   // ROM area writes
    send_access(mmm_pkg::MODE_WRITE, 16'hFFFF, 8'h22);
    send_access(mmm_pkg::MODE_WRITE, 16'h0000, 8'h00);
    send_access(mmm_pkg::MODE_READ,  16'h0000, 8'hFF);
    send_access(mmm_pkg::MODE_WRITE, 16'h7FFF, 8'hFF);
    send_access(mmm_pkg::MODE_READ,  16'h7FFF, 8'h00);
    send_access(mmm_pkg::MODE_LOAD_OS,    16'hFFFF, 8'h5A);  // offset wraps to 3FFF
    send_access(mmm_pkg::MODE_READ,       16'hFFFF, 8'h00);
    send_access(mmm_pkg::MODE_LOAD_PAGED, 16'h4000, 8'hC3);  // offset wraps to 0
    send_access(mmm_pkg::MODE_READ,       16'h8000, 8'h00);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        long_hold_req = 1'b1;
        burst_left    = LONG_HOLD + 64;
      end
      pick = $urandom_range(0, 99);
      if (pick < 25)
        send_access(mmm_pkg::MODE_WRITE, 16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
      else if (pick < 45)
        send_access(mmm_pkg::MODE_READ,
                    ram_addrs[$urandom_range(0, ram_addrs.size() - 1)], 8'($urandom));
      else if (pick < 57)
        send_access($urandom_range(0, 1) ? mmm_pkg::MODE_LOAD_OS : mmm_pkg::MODE_LOAD_PAGED,
                    16'($urandom), 8'($urandom));
      else if (pick < 64)
        send_access(mmm_pkg::MODE_READ,
                    {2'b11, os_offs[$urandom_range(0, os_offs.size() - 1)]}, 8'($urandom));
      else if (pick < 70)
        send_access(mmm_pkg::MODE_READ,
                    {2'b10, paged_offs[$urandom_range(0, paged_offs.size() - 1)]},
                    8'($urandom));
      else if (pick < 92)
        send_access($urandom_range(0, 1) ? mmm_pkg::MODE_WRITE : mmm_pkg::MODE_READ,
                    {mmm_pkg::IO_PAGE_HI, 8'($urandom)}, 8'($urandom));
      else if (pick < 96)
        send_access(mmm_pkg::MODE_WRITE, 16'($urandom_range(16'h8000, 16'hFDFF)),
                    8'($urandom));
      else
        send_access(mmm_pkg::MODE_WRITE, 16'($urandom_range(16'hFF00, 16'hFFFF)),
                    8'($urandom));
    end
    s_axis_tvalid <= 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/mmm_pkg.sv
hdl/mmm_mem.sv
hdl/mmm_io.sv
hdl/micro_memory_map_with_io_registers.sv
dv/micro_memory_map_with_io_registers_tb.sv
